// ===== rtl/bpfm_pkg.sv =====
// Package for the buffer pool frame manager: command and disk op codes,
// frame record and scan result types. No dependencies.
package bpfm_pkg;

   localparam int PAGE_W = 31;

   typedef enum logic [2:0] {
      CMD_FETCH     = 3'd0,
      CMD_NEW       = 3'd1,
      CMD_UNPIN     = 3'd2,
      CMD_FLUSH     = 3'd3,
      CMD_DELETE    = 3'd4,
      CMD_FLUSH_ALL = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      DOP_NONE    = 2'd0,
      DOP_READ    = 2'd1,
      DOP_WRITE   = 2'd2,
      DOP_DEALLOC = 2'd3
   } disk_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FREEPOP,
      ST_LRUREM,
      ST_EMIT_WB,
      ST_EMIT_MAIN,
      ST_FA_SCAN,
      ST_FA_EMIT,
      ST_FA_DONE,
      ST_FREEPUSH
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [7:0]        pins;
      logic [PAGE_W-1:0] page;
   } frame_rec_type;

   typedef struct packed {
      logic       valid;
      logic       dirty;
      logic [7:0] pins;
      logic [PAGE_W-1:0] page;
   } probe_type;

   typedef struct packed {
      logic              set_en;
      logic              set_valid;
      logic              set_dirty;
      logic [7:0]        set_pins;
      logic [PAGE_W-1:0] set_page;
   } frame_wr_type;

endpackage

// ===== rtl/bpfm_cell.sv =====
// One frame cell: holds a frame record; a write sets it whole, a clear drops its dirty bit.
// Depends on bpfm_pkg.
module bpfm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bpfm_pkg::frame_wr_type wr,
   input  logic                  clr_dirty,
   output bpfm_pkg::frame_rec_type rec
);
   import bpfm_pkg::*;

   frame_rec_type rec_ff, rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (clr_dirty) rec_in.dirty = 1'b0;
      if (wr.set_en) begin
         rec_in.valid = wr.set_valid;
         rec_in.dirty = wr.set_dirty;
         rec_in.pins  = wr.set_pins;
         rec_in.page  = wr.set_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
         rec_ff.dirty <= 1'b0;
         rec_ff.pins  <= '0;
         rec_ff.page  <= rec_in.page;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;
endmodule

// ===== rtl/bpfm_order_cell.sv =====
// One slot of the replacement order chain; shifts down from its upper
// neighbour when an entry ahead of it is removed. Depends on bpfm_pkg.
module bpfm_order_cell #(
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             load,
   input  logic [IDX_W-1:0] load_val,
   input  logic             shift,
   input  logic [IDX_W-1:0] upper,
   output logic [IDX_W-1:0] value
);
   import bpfm_pkg::*;

   logic [IDX_W-1:0] val_ff, val_in;

   always_comb begin
      val_in = val_ff;
      if (shift) val_in = upper;
      if (load)  val_in = load_val;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value = val_ff;
endmodule

// ===== rtl/buffer_pool_frame_manager.sv =====
// Top level of the buffer pool frame manager: sequencer over a row of frame
// cells, a free frame FIFO and a replacement order chain. Depends on bpfm_pkg.
//
//  channel | dir | tdata (low bit up)                      | tuser/tlast
//  req     | in  | cmd[2:0], page_id[33:3], mark_dirty[34] | -
//  rsp     | out | status[0], frame[4:1], disk_op[6:5],    | tlast = last
//          |     | disk_page[37:7]                         |
//
// A page search walks one frame per cycle, then removal from the replacement
// order walks the chain one slot per cycle. Flush all walks every frame once,
// stopping at each dirty one to emit its write. Reset is synchronous; the free
// FIFO is filled with every frame in order after reset, and requests wait for
// that. A stalled rsp holds the sequencer.
module buffer_pool_frame_manager #(
   parameter int NUM_FRAMES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd, page_id, mark_dirty
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, frame, disk_op, disk_page
   output logic        rsp_tlast
);
   import bpfm_pkg::*;

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam logic [CNT_W-1:0] NF_CNT = CNT_W'(NUM_FRAMES);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   state_type state_ff, state_in;

   logic [2:0]        cmd_ff, cmd_in;
   logic [PAGE_W-1:0] pg_ff, pg_in;
   logic              dirty_ff, dirty_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hitf_ff, hitf_in;
   logic              any_ff, any_in;   // flush all: a write was emitted
   logic [IDX_W-1:0]  tgt_ff, tgt_in;   // frame being worked on
   logic [PAGE_W-1:0] wbpg_ff, wbpg_in;

   // free FIFO memory
   logic [IDX_W-1:0]  free_mem [NUM_FRAMES];
   logic [IDX_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [IDX_W-1:0]  init_ff, init_in;
   logic              init_busy_ff, init_busy_in;
   logic              fpush_en;
   logic [IDX_W-1:0]  fpush_addr, fpush_val;
   logic [IDX_W-1:0]  free_rd;

   // replacement order chain
   logic [IDX_W-1:0]  ord_val [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] ord_shift, ord_load;
   logic [IDX_W-1:0]  ord_load_val;
   logic [CNT_W-1:0]  lru_cnt_ff, lru_cnt_in;
   logic [CNT_W-1:0]  rm_ff, rm_in;      // removal walk position
   logic              found_ff, found_in;

   // output register
   logic        ov_ff, ov_in;
   logic        ost_ff, ost_in, olast_ff, olast_in;
   logic [IDX_W-1:0] ofr_ff, ofr_in;
   logic [1:0]  oop_ff, oop_in;
   logic [PAGE_W-1:0] opg_ff, opg_in;

   frame_rec_type recs [NUM_FRAMES];
   frame_wr_type  wr_vec [NUM_FRAMES];
   frame_wr_type  wr;
   logic [IDX_W-1:0] wr_idx;
   logic          clr_all_one;
   logic [IDX_W-1:0] clr_idx;
   frame_rec_type cur, tgt_rec;

   genvar g;
   generate
      for (g = 0; g < NUM_FRAMES; g++) begin : g_cells
         bpfm_cell u_cell (
            .clock(clock), .reset(reset),
            .wr(wr_vec[g]),
            .clr_dirty(clr_all_one && clr_idx == IDX_W'(g)),
            .rec(recs[g])
         );
         bpfm_order_cell #(.IDX_W(IDX_W)) u_ord (
            .clock(clock), .load(ord_load[g]), .load_val(ord_load_val),
            .shift(ord_shift[g]),
            .upper((g == NUM_FRAMES-1) ? ord_val[g] : ord_val[(g+1) % NUM_FRAMES]),
            .value(ord_val[g])
         );
         always_comb begin
            wr_vec[g] = wr;
            wr_vec[g].set_en = wr.set_en && (wr_idx == IDX_W'(g));
         end
      end
   endgenerate

   assign cur     = recs[scan_ff];
   assign tgt_rec = recs[tgt_ff];

   logic out_free;
   assign out_free  = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !init_busy_ff && !ov_ff;

   logic [IDX_W-1:0] free_tail;
   assign free_tail = IDX_W'((CNT_W+1)'(free_head_ff) + (CNT_W+1)'(free_cnt_ff)
                             - ((CNT_W+1)'(free_head_ff) + (CNT_W+1)'(free_cnt_ff)
                                >= (CNT_W+1)'(NUM_FRAMES) ? (CNT_W+1)'(NUM_FRAMES)
                                                          : (CNT_W+1)'(0)));

   // FIFO memory writes: init sweep or push; head entry read every cycle
   always_ff @(posedge clock) begin
      if (init_busy_ff) free_mem[init_ff] <= init_ff;
      else if (fpush_en) free_mem[fpush_addr] <= fpush_val;
      free_rd <= free_mem[free_head_ff];
   end

   always_comb begin
      init_in      = init_ff;
      init_busy_in = init_busy_ff;
      if (init_busy_ff) begin
         init_in = init_ff + IDX_ONE;
         if (init_ff == IDX_W'(NUM_FRAMES-1)) init_busy_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_tvalid && req_tready)
               state_in = (cmd_type'(req_tdata[2:0]) == CMD_FLUSH_ALL) ? ST_FA_SCAN : ST_SCAN;
         ST_SCAN:
            if (scan_ff == IDX_W'(NUM_FRAMES-1)) state_in = ST_DECIDE;
         ST_DECIDE:
            if (out_free) begin
               case (cmd_ff)
                  CMD_FETCH:
                     if (hit_ff) state_in = ST_LRUREM;
                     else if (free_cnt_ff != '0) state_in = ST_FREEPOP;
                     else if (lru_cnt_ff != '0) state_in = ST_LRUREM;
                     else state_in = ST_IDLE;
                  CMD_NEW:
                     if (hit_ff) state_in = ST_IDLE;
                     else if (free_cnt_ff != '0) state_in = ST_FREEPOP;
                     else if (lru_cnt_ff != '0) state_in = ST_LRUREM;
                     else state_in = ST_IDLE;
                  CMD_DELETE:
                     if (hit_ff && recs[hitf_ff].pins == '0) state_in = ST_LRUREM;
                     else state_in = ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         ST_FREEPOP:  state_in = ST_EMIT_WB;
         ST_LRUREM:
            if (rm_ff >= lru_cnt_ff) state_in = ST_EMIT_WB;
         ST_EMIT_WB:
            if (out_free) state_in = ST_EMIT_MAIN;
         ST_EMIT_MAIN:
            if (out_free) state_in = (cmd_ff == CMD_DELETE) ? ST_FREEPUSH : ST_IDLE;
         ST_FREEPUSH: state_in = ST_IDLE;
         ST_FA_SCAN:
            if (cur.valid && cur.dirty) state_in = ST_FA_EMIT;
            else if (scan_ff == IDX_W'(NUM_FRAMES-1)) state_in = any_ff ? ST_IDLE : ST_FA_DONE;
         ST_FA_EMIT:
            if (out_free) begin
               if (scan_ff == IDX_W'(NUM_FRAMES-1)) state_in = ST_IDLE;
               else state_in = ST_FA_SCAN;
            end
         ST_FA_DONE:
            if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   logic fa_more;
   always_comb begin
      cmd_in = cmd_ff; pg_in = pg_ff; dirty_in = dirty_ff;
      scan_in = scan_ff; hit_in = hit_ff; hitf_in = hitf_ff; any_in = any_ff;
      tgt_in = tgt_ff; wbpg_in = wbpg_ff;
      free_head_in = free_head_ff; free_cnt_in = free_cnt_ff;
      lru_cnt_in = lru_cnt_ff; rm_in = rm_ff; found_in = found_ff;
      fpush_en = 1'b0; fpush_addr = free_tail; fpush_val = tgt_ff;
      ord_shift = '0; ord_load = '0; ord_load_val = hitf_ff;
      wr = '0; wr_idx = tgt_ff;
      clr_all_one = 1'b0; clr_idx = scan_ff;
      ov_in = ov_ff && !rsp_tready;
      ost_in = ost_ff; olast_in = olast_ff; ofr_in = ofr_ff; oop_in = oop_ff;
      opg_in = opg_ff;
      fa_more = 1'b0;

      case (state_ff)
         ST_IDLE:
            if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[2:0];
               pg_in = req_tdata[33:3];
               dirty_in = req_tdata[34];
               scan_in = '0; hit_in = 1'b0; any_in = 1'b0;
            end
         ST_SCAN: begin
            if (!hit_ff && cur.valid && cur.page == pg_ff) begin
               hit_in = 1'b1; hitf_in = scan_ff;
            end
            scan_in = scan_ff + IDX_ONE;
         end
         ST_DECIDE:
            if (out_free) begin
               rm_in = '0; found_in = 1'b0;
               case (cmd_ff)
                  CMD_FETCH:
                     if (hit_ff) begin
                        tgt_in = hitf_ff;
                     end else if (free_cnt_ff == '0 && lru_cnt_ff == '0) begin
                        ov_in = 1'b1; ost_in = 1'b1; ofr_in = '0; oop_in = DOP_NONE;
                        opg_in = pg_ff; olast_in = 1'b1;
                     end else if (free_cnt_ff == '0) begin
                        tgt_in = ord_val[0];
                     end
                  CMD_NEW:
                     if (hit_ff || (free_cnt_ff == '0 && lru_cnt_ff == '0)) begin
                        ov_in = 1'b1; ost_in = 1'b1; ofr_in = '0; oop_in = DOP_NONE;
                        opg_in = pg_ff; olast_in = 1'b1;
                     end else if (free_cnt_ff == '0) begin
                        tgt_in = ord_val[0];
                     end
                  CMD_UNPIN: begin
                     ov_in = 1'b1; ofr_in = '0; oop_in = DOP_NONE; opg_in = pg_ff;
                     olast_in = 1'b1;
                     if (!hit_ff || recs[hitf_ff].pins == '0) begin
                        ost_in = 1'b1;
                     end else begin
                        ost_in = 1'b0; ofr_in = hitf_ff;
                        wr_idx = hitf_ff;
                        wr.set_en = 1'b1; wr.set_valid = 1'b1;
                        wr.set_dirty = recs[hitf_ff].dirty | dirty_ff;
                        wr.set_pins = recs[hitf_ff].pins - 8'd1;
                        wr.set_page = recs[hitf_ff].page;
                        // pins return to zero only from one; the frame is then
                        // never already in the order
                        if (recs[hitf_ff].pins == 8'd1 && lru_cnt_ff < NF_CNT) begin
                           ord_load[lru_cnt_ff[IDX_W-1:0]] = 1'b1;
                           lru_cnt_in = lru_cnt_ff + CNT_ONE;
                        end
                     end
                  end
                  CMD_FLUSH: begin
                     ov_in = 1'b1; opg_in = pg_ff; olast_in = 1'b1;
                     if (!hit_ff) begin
                        ost_in = 1'b1; ofr_in = '0; oop_in = DOP_NONE;
                     end else begin
                        ost_in = 1'b0; ofr_in = hitf_ff; oop_in = DOP_WRITE;
                        wr_idx = hitf_ff;
                        wr.set_en = 1'b1; wr.set_valid = 1'b1; wr.set_dirty = 1'b0;
                        wr.set_pins = recs[hitf_ff].pins; wr.set_page = recs[hitf_ff].page;
                     end
                  end
                  CMD_DELETE:
                     if (!hit_ff || recs[hitf_ff].pins != '0) begin
                        ov_in = 1'b1; ost_in = hit_ff; ofr_in = '0; oop_in = DOP_NONE;
                        opg_in = pg_ff; olast_in = 1'b1;
                     end else begin
                        tgt_in = hitf_ff;
                     end
                  default: begin
                     ov_in = 1'b1; ost_in = 1'b1; ofr_in = '0; oop_in = DOP_NONE;
                     opg_in = pg_ff; olast_in = 1'b1;
                  end
               endcase
            end
         ST_FREEPOP: begin
            tgt_in = free_rd;
            free_head_in = (free_head_ff == IDX_W'(NUM_FRAMES-1)) ? '0 : free_head_ff + IDX_ONE;
            free_cnt_in = free_cnt_ff - CNT_ONE;
         end
         ST_LRUREM:
            // walk the chain: once the entry is found, every later slot moves down
            if (rm_ff < lru_cnt_ff) begin
               if (found_ff || ord_val[rm_ff[IDX_W-1:0]] == tgt_ff) begin
                  found_in = 1'b1;
                  ord_shift[rm_ff[IDX_W-1:0]] = 1'b1;
               end
               rm_in = rm_ff + CNT_ONE;
            end else if (found_ff) begin
               lru_cnt_in = lru_cnt_ff - CNT_ONE;
            end
         ST_EMIT_WB:
            if (out_free) begin
               if (!(cmd_ff == CMD_FETCH && hit_ff) && tgt_rec.valid && tgt_rec.dirty) begin
                  ov_in = 1'b1; ost_in = 1'b0; ofr_in = tgt_ff; oop_in = DOP_WRITE;
                  opg_in = tgt_rec.page; olast_in = 1'b0;
               end
            end
         ST_EMIT_MAIN:
            if (out_free) begin
               ov_in = 1'b1; ost_in = 1'b0; ofr_in = tgt_ff; opg_in = pg_ff;
               olast_in = 1'b1;
               wr.set_en = 1'b1; wr.set_page = pg_ff;
               case (cmd_ff)
                  CMD_FETCH:
                     if (hit_ff) begin
                        oop_in = DOP_NONE;
                        wr.set_valid = 1'b1; wr.set_dirty = tgt_rec.dirty;
                        wr.set_page = tgt_rec.page;
                        wr.set_pins = (tgt_rec.pins == 8'hFF) ? 8'hFF : tgt_rec.pins + 8'd1;
                     end else begin
                        oop_in = DOP_READ;
                        wr.set_valid = 1'b1; wr.set_dirty = 1'b0; wr.set_pins = 8'd1;
                     end
                  CMD_NEW: begin
                     oop_in = DOP_NONE;
                     wr.set_valid = 1'b1; wr.set_dirty = 1'b1; wr.set_pins = 8'd1;
                  end
                  default: begin
                     oop_in = DOP_DEALLOC;
                     wr.set_valid = 1'b0; wr.set_dirty = 1'b0; wr.set_pins = '0;
                  end
               endcase
            end
         ST_FREEPUSH:
            if (free_cnt_ff < NF_CNT) begin
               fpush_en = 1'b1;
               free_cnt_in = free_cnt_ff + CNT_ONE;
            end
         ST_FA_SCAN:
            if (cur.valid && cur.dirty) begin
               wbpg_in = cur.page;
            end else begin
               clr_all_one = 1'b1;
               scan_in = scan_ff + IDX_ONE;
            end
         ST_FA_EMIT:
            if (out_free) begin
               fa_more = 1'b0;
               for (int k = 0; k < NUM_FRAMES; k++)
                  if (IDX_W'(k) > scan_ff && recs[k].valid && recs[k].dirty) fa_more = 1'b1;
               ov_in = 1'b1; ost_in = 1'b0; ofr_in = scan_ff; oop_in = DOP_WRITE;
               opg_in = wbpg_ff; olast_in = !fa_more;
               any_in = 1'b1;
               clr_all_one = 1'b1;
               scan_in = scan_ff + IDX_ONE;
            end
         ST_FA_DONE:
            if (out_free) begin
               ov_in = 1'b1; ost_in = 1'b0; ofr_in = '0; oop_in = DOP_NONE;
               opg_in = '0; olast_in = 1'b1;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         free_head_ff <= '0;
         free_cnt_ff <= NF_CNT;
         lru_cnt_ff <= '0;
         init_ff <= '0;
         init_busy_ff <= 1'b1;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_head_ff <= free_head_in;
         free_cnt_ff <= free_cnt_in;
         lru_cnt_ff <= lru_cnt_in;
         init_ff <= init_in;
         init_busy_ff <= init_busy_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; pg_ff <= pg_in; dirty_ff <= dirty_in;
      scan_ff <= scan_in; hit_ff <= hit_in; hitf_ff <= hitf_in; any_ff <= any_in;
      tgt_ff <= tgt_in; wbpg_ff <= wbpg_in;
      rm_ff <= rm_in; found_ff <= found_in;
      ost_ff <= ost_in; olast_ff <= olast_in; ofr_ff <= ofr_in; oop_ff <= oop_in;
      opg_ff <= opg_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {2'b00, opg_ff, oop_ff, 4'(ofr_ff), ost_ff};
endmodule
